@@ design/column_heights_to_row_spans_core_defines.svh @@
// assertion macros used by the checker file
`ifndef COLUMN_HEIGHTS_TO_ROW_SPANS_CORE_DEFINES_SVH
`define COLUMN_HEIGHTS_TO_ROW_SPANS_CORE_DEFINES_SVH

// checked only while out of reset
`define CH2RS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CH2RS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ch2rs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch2rs_pkg
// types and constants of the column-height to row-span converter
// ----------------------------------------------------------------------------
package ch2rs_pkg;

  localparam int WALL_W     = 15;
  localparam int HGT_SHIFT  = 3;
  localparam int HGT_W      = WALL_W - HGT_SHIFT;
  localparam int COL_W      = 9;
  localparam int LVL_W      = 7;
  localparam int SPAN_LVL_W = 6;
  localparam int CENTER_W   = 7;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 7'd64;

  typedef struct packed {
    logic [WALL_W-1:0] wall_height;
    logic              is_last_column;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]      span_start_x;
    logic [COL_W-1:0]      span_end_x;
    logic [SPAN_LVL_W-1:0] span_level;
    logic                  last_of_run;
  } span_t;

  // one column as handed from the front to the level engine
  typedef struct packed {
    logic [HGT_W-1:0] height;
    logic             is_last;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] prev_col;
  } cmd_t;

endpackage

@@ design/ch2rs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch2rs_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module ch2rs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/ch2rs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch2rs_front
// takes column requests, turns the height into a level and numbers the column
// ----------------------------------------------------------------------------
module ch2rs_front import ch2rs_pkg::*; #(
  parameter int MAX_COLUMNS = 512
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  input  in_item_t item_i,
  output logic     full,
  output cmd_t     cmd_o,
  output logic     cmd_push_o,
  input  logic     cmd_full_i
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);

  logic [COL_W-1:0] col_q, col_d;
  logic             accept;

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  always_comb begin
    cmd_o.height   = item_i.wall_height[WALL_W-1:HGT_SHIFT];
    cmd_o.is_last  = item_i.is_last_column;
    cmd_o.col      = col_q;
    cmd_o.prev_col = (col_q == '0) ? LAST_COL : col_q - 1'b1;
    cmd_push_o     = accept;
  end

  always_comb begin
    col_d = col_q;
    if (accept) begin
      if (item_i.is_last_column || (col_q >= LAST_COL)) begin
        col_d = '0;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

endmodule

@@ design/ch2rs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch2rs_back
// level engine: walks the current level down or up and emits spans
// ----------------------------------------------------------------------------
module ch2rs_back import ch2rs_pkg::*; #(
  parameter int MAX_HALF_HEIGHT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output span_t               span_o,
  output logic                span_push_o,
  input  logic                span_full_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CENTER_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_HALF_HEIGHT);
  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_HALF_HEIGHT);
  localparam logic [LVL_W-1:0] RESET_LVL =
    (LVL_W'(CENTER_RESET) > MAX_LVL) ? MAX_LVL : LVL_W'(CENTER_RESET);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DROP = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_READ = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CENTER_W-1:0] center_q, center_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [LVL_W-1:0]    tgt_q, tgt_d;
  logic                flush_q, flush_d;
  cmd_t                cmd_q, cmd_d;
  logic [COL_W-1:0]    rdata_q;

  logic [COL_W-1:0]    mem [MAX_HALF_HEIGHT];
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;

  logic [LVL_W-1:0]    eff_center;
  logic [LVL_W-1:0]    lvl_dec, lvl_inc;
  logic                drop;

  assign cfg_ready_o = 1'b1;
  assign center_d    = (cfg_valid_i) ? cfg_data_i : center_q;
  assign eff_center  = (LVL_W'(center_q) > MAX_LVL) ? MAX_LVL : LVL_W'(center_q);
  assign lvl_dec     = lvl_q - 1'b1;
  assign lvl_inc     = lvl_q + 1'b1;
  assign drop        = cmd_i.height < HGT_W'(lvl_q);
  assign mem_waddr   = lvl_dec[IDX_W-1:0];
  assign mem_raddr   = lvl_q[IDX_W-1:0];

  always_comb begin
    span_o.span_start_x = rdata_q;
    span_o.span_end_x   = flush_q ? cmd_q.col : cmd_q.prev_col;
    span_o.span_level   = SPAN_LVL_W'(lvl_q[IDX_W-1:0]);
    // final span unless a row-end flush still has levels to cover
    span_o.last_of_run  = (lvl_inc >= tgt_q) &&
                          !(!flush_q && cmd_q.is_last && (lvl_inc < eff_center));
  end

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    tgt_d       = tgt_q;
    flush_d     = flush_q;
    cmd_d       = cmd_q;
    cmd_pop_o   = 1'b0;
    span_push_o = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          flush_d   = 1'b0;
          if (drop) begin
            tgt_d   = LVL_W'(cmd_i.height);
            state_d = ST_DROP;
          end else begin
            tgt_d   = (cmd_i.height > HGT_W'(eff_center)) ? eff_center
                                                          : LVL_W'(cmd_i.height);
            state_d = ST_CHK;
          end
        end
      end
      ST_DROP: begin
        mem_we = (lvl_dec < MAX_LVL);
        lvl_d  = lvl_dec;
        if (lvl_dec == tgt_q) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (lvl_q < tgt_q) begin
          state_d = ST_READ;
        end else if (cmd_q.is_last && !flush_q) begin
          flush_d = 1'b1;
          tgt_d   = eff_center;
        end else begin
          if (cmd_q.is_last) begin
            lvl_d = eff_center;
          end
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!span_full_i) begin
          span_push_o = 1'b1;
          lvl_d       = lvl_inc;
          state_d     = ST_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      center_q <= CENTER_RESET;
      lvl_q    <= RESET_LVL;
      tgt_q    <= '0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      center_q <= center_d;
      lvl_q    <= lvl_d;
      tgt_q    <= tgt_d;
      flush_q  <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // start column per level
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_q.col;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

@@ design/column_heights_to_row_spans_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_heights_to_row_spans_core
// turns a per-column wall height profile into floor/ceiling row spans
// ----------------------------------------------------------------------------
//   channel   handshake                 payload
//   input     push / full               item_i  (in_item_t)
//   result    pop / empty               span_o  (span_t)
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (center_row)
//
// in the level engine a column passes idle and level check, a drop step per
// level passed on a drop, per span level check, start-column memory read and
// write into the result queue, and one more level check on a row-end column.
// front and level engine are parted by a 4-entry command queue, results by a
// 4-entry queue; a full result queue stalls the engine only. reset clears the
// queues and column counter, puts the level at reset center; no memory pass.
// ----------------------------------------------------------------------------
module column_heights_to_row_spans_core import ch2rs_pkg::*; #(
  parameter int MAX_HALF_HEIGHT = 64,
  parameter int MAX_COLUMNS     = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            item_i,
  input  logic                pop,
  output logic                empty,
  output span_t               span_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CENTER_W-1:0] cfg_data_i
);

  localparam int QUEUE_DEPTH = 4;

  cmd_t  front_cmd, back_cmd;
  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
  span_t back_span;
  logic  span_push, span_full;

  ch2rs_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .item_i     (item_i),
    .full       (full),
    .cmd_o      (front_cmd),
    .cmd_push_o (cmd_push),
    .cmd_full_i (cmd_full)
  );

  ch2rs_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  ch2rs_back #(
    .MAX_HALF_HEIGHT(MAX_HALF_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .span_o      (back_span),
    .span_push_o (span_push),
    .span_full_i (span_full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  ch2rs_fifo #(
    .WIDTH($bits(span_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_span_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (span_push),
    .data_i  (back_span),
    .full_o  (span_full),
    .pop_i   (pop),
    .data_o  (span_o),
    .empty_o (empty)
  );

endmodule

@@ design/ch2rs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ch2rs_checker
// port-level checks of the row-span converter, bound to the top level
// ----------------------------------------------------------------------------
`include "column_heights_to_row_spans_core_defines.svh"

module ch2rs_checker import ch2rs_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  full,
  input logic  pop,
  input logic  empty,
  input span_t span_o
);

  // queues come out of reset drained
  `CH2RS_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "result seen in reset")
  `CH2RS_ASSERT_ALWAYS(a_not_full_in_reset, clk_i, !rst_ni |-> !full, "input full in reset")

  // a waiting result holds until taken
  `CH2RS_ASSERT(a_result_holds, clk_i, rst_ni,
    (!empty && !pop) |=> (!empty && $stable(span_o)), "waiting result changed")

endmodule

bind column_heights_to_row_spans_core ch2rs_checker u_checker (.*);
